[rtl/c8eu_pkg.sv]
// ----------------------------------------------------------------------------
// c8eu_pkg: shared types and constants
// Operation codes, status bit positions and the result item layout.
// ----------------------------------------------------------------------------
`default_nettype none
package c8eu_pkg;

  typedef enum logic [5:0] {
    OP_BRK = 6'd0,  OP_CLC = 6'd1,  OP_SEC = 6'd2,  OP_CLI = 6'd3,
    OP_SEI = 6'd4,  OP_CLD = 6'd5,  OP_SED = 6'd6,  OP_CLV = 6'd7,
    OP_ASL = 6'd8,  OP_LSR = 6'd9,  OP_ADC = 6'd10, OP_SBC = 6'd11,
    OP_BIT = 6'd12, OP_ROL = 6'd13, OP_ROR = 6'd14, OP_ORA = 6'd15,
    OP_AND = 6'd16, OP_EOR = 6'd17, OP_JSR = 6'd18, OP_JMP = 6'd19,
    OP_RTI = 6'd20, OP_RTS = 6'd21, OP_LDY = 6'd22, OP_LDX = 6'd23,
    OP_LDA = 6'd24, OP_STY = 6'd25, OP_STX = 6'd26, OP_STA = 6'd27,
    OP_PHP = 6'd28, OP_PLA = 6'd29, OP_PHA = 6'd30, OP_PLP = 6'd31,
    OP_TXA = 6'd32, OP_TYA = 6'd33, OP_TXS = 6'd34, OP_TAY = 6'd35,
    OP_TAX = 6'd36, OP_TSX = 6'd37, OP_CPY = 6'd38, OP_CMP = 6'd39,
    OP_CPX = 6'd40, OP_DEY = 6'd41, OP_DEX = 6'd42, OP_DEC = 6'd43,
    OP_INY = 6'd44, OP_INX = 6'd45, OP_INC = 6'd46, OP_BPL = 6'd47,
    OP_BMI = 6'd48, OP_BVC = 6'd49, OP_BVS = 6'd50, OP_BCC = 6'd51,
    OP_BCS = 6'd52, OP_BNE = 6'd53, OP_BEQ = 6'd54, OP_NOP = 6'd55
  } op_t;

  localparam int unsigned FL_C = 0;
  localparam int unsigned FL_Z = 1;
  localparam int unsigned FL_I = 2;
  localparam int unsigned FL_D = 3;
  localparam int unsigned FL_B = 4;
  localparam int unsigned FL_V = 6;
  localparam int unsigned FL_N = 7;

  localparam logic [7:0] STACK_PAGE = 8'h01;

  typedef struct packed {
    logic [5:0]  action;
    logic [7:0]  operand;
    logic [15:0] operand_word;
    logic [15:0] mem_address;
    logic [15:0] pc_in;
  } in_item_t;

  typedef struct packed {
    logic        bus_write;
    logic [15:0] bus_address;
    logic [7:0]  bus_data;
    logic [7:0]  acc_out;
    logic [7:0]  xreg_out;
    logic [7:0]  yreg_out;
    logic [7:0]  sp_out;
    logic [7:0]  flags_out;
    logic [15:0] pc_out;
    logic        last;
  } out_item_t;

  // architectural registers
  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] xreg;
    logic [7:0] yreg;
    logic [7:0] sp;
    logic [7:0] flags;
  } regs_t;

  // what the execute logic hands to the result sequencer
  typedef struct packed {
    regs_t       regs;
    logic [15:0] pc;
    logic [1:0]  count;      // number of result items minus one
    logic        wr;         // single memory write
    logic [15:0] wr_addr;
    logic [7:0]  wr_data;
    logic [7:0]  push0;      // stack bytes in push order
    logic [7:0]  push1;
    logic [7:0]  push2;
    logic        pushes;     // results are stack pushes
    logic [7:0]  sp_first;   // sp at first push
  } exec_t;

endpackage
`default_nettype wire

[rtl/c8eu_if.sv]
// ----------------------------------------------------------------------------
// c8eu_in_if / c8eu_out_if: valid/ready item channels
// ----------------------------------------------------------------------------
`default_nettype none
interface c8eu_in_if import c8eu_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface c8eu_out_if import c8eu_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/c8eu_alu.sv]
// ----------------------------------------------------------------------------
// c8eu_alu: instruction execute logic
// Computes new registers, pc and the memory writes for one instruction.
// ----------------------------------------------------------------------------
`default_nettype none
module c8eu_alu import c8eu_pkg::*; (
  input  wire in_item_t item,
  input  wire regs_t    regs,
  output exec_t         ex
);

  logic [7:0] m;
  logic [7:0] fl;
  logic [8:0] sum;
  logic [7:0] addend;
  logic [7:0] v;
  logic [8:0] cmp;
  logic [7:0] cmp_reg;
  logic       cond;
  logic       is_br;
  logic [7:0] sp_m1;
  logic [7:0] sp_m2;

  always_comb begin
    m       = item.operand;
    ex      = '0;
    ex.regs = regs;
    ex.pc   = item.pc_in;
    fl      = regs.flags;
    addend  = (item.action == OP_SBC) ? ~m : m;
    sum     = {1'b0, regs.acc} + {1'b0, addend} + {8'd0, regs.flags[FL_C]};
    cmp_reg = (item.action == OP_CPY) ? regs.yreg :
              (item.action == OP_CPX) ? regs.xreg : regs.acc;
    cmp     = {1'b0, cmp_reg} - {1'b0, m};
    sp_m1   = regs.sp - 8'd1;
    sp_m2   = regs.sp - 8'd2;
    v       = '0;
    cond    = 1'b0;
    is_br   = 1'b0;
    ex.sp_first = regs.sp;
    case (item.action)
      OP_BRK: begin
        fl[FL_B]  = 1'b1;
        ex.pushes = 1'b1;
        ex.count  = 2'd2;
        ex.push0  = item.pc_in[15:8];
        ex.push1  = item.pc_in[7:0];
        ex.push2  = fl;
        ex.regs.sp = regs.sp - 8'd3;
        ex.pc     = item.operand_word;
      end
      OP_CLC: fl[FL_C] = 1'b0;
      OP_SEC: fl[FL_C] = 1'b1;
      OP_CLI: fl[FL_I] = 1'b0;
      OP_SEI: fl[FL_I] = 1'b1;
      OP_CLD: fl[FL_D] = 1'b0;
      OP_SED: fl[FL_D] = 1'b1;
      OP_CLV: fl[FL_V] = 1'b0;
      OP_ASL, OP_LSR, OP_ROL, OP_ROR, OP_DEC, OP_INC: begin
        case (item.action)
          OP_ASL: begin v = {m[6:0], 1'b0};          fl[FL_C] = m[7]; end
          OP_LSR: begin v = {1'b0, m[7:1]};          fl[FL_C] = m[0]; end
          OP_ROL: begin v = {m[6:0], regs.flags[FL_C]}; fl[FL_C] = m[7]; end
          OP_ROR: begin v = {regs.flags[FL_C], m[7:1]}; fl[FL_C] = m[0]; end
          OP_DEC: v = m - 8'd1;
          default: v = m + 8'd1;
        endcase
        fl[FL_Z]   = (v == 8'd0);
        fl[FL_N]   = v[7];
        ex.wr      = 1'b1;
        ex.wr_addr = item.mem_address;
        ex.wr_data = v;
      end
      OP_ADC, OP_SBC: begin
        fl[FL_V]    = ~(regs.acc[7] ^ addend[7]) & (regs.acc[7] ^ sum[7]);
        fl[FL_C]    = sum[8];
        ex.regs.acc = sum[7:0];
        fl[FL_Z]    = (sum[7:0] == 8'd0);
        fl[FL_N]    = sum[7];
      end
      OP_BIT: begin
        fl[FL_Z] = ((regs.acc & m) == 8'd0);
        fl[FL_V] = m[6];
        fl[FL_N] = m[7];
      end
      OP_ORA, OP_AND, OP_EOR, OP_LDA, OP_PLA, OP_TXA, OP_TYA: begin
        case (item.action)
          OP_ORA:  v = regs.acc | m;
          OP_AND:  v = regs.acc & m;
          OP_EOR:  v = regs.acc ^ m;
          OP_TXA:  v = regs.xreg;
          OP_TYA:  v = regs.yreg;
          default: v = m;
        endcase
        if (item.action == OP_PLA) ex.regs.sp = regs.sp + 8'd1;
        ex.regs.acc = v;
        fl[FL_Z] = (v == 8'd0);
        fl[FL_N] = v[7];
      end
      OP_JSR: begin
        ex.pushes  = 1'b1;
        ex.count   = 2'd1;
        ex.push0   = item.pc_in[15:8];
        ex.push1   = item.pc_in[7:0];
        ex.regs.sp = sp_m2;
        ex.pc      = item.operand_word;
      end
      OP_JMP: ex.pc = item.operand_word;
      OP_RTI: begin
        fl         = m;
        ex.regs.sp = regs.sp + 8'd3;
        ex.pc      = item.operand_word;
      end
      OP_RTS: begin
        ex.regs.sp = regs.sp + 8'd2;
        ex.pc      = item.operand_word;
      end
      OP_LDY, OP_TAY, OP_DEY, OP_INY: begin
        case (item.action)
          OP_LDY:  v = m;
          OP_TAY:  v = regs.acc;
          OP_DEY:  v = regs.yreg - 8'd1;
          default: v = regs.yreg + 8'd1;
        endcase
        ex.regs.yreg = v;
        fl[FL_Z] = (v == 8'd0);
        fl[FL_N] = v[7];
      end
      OP_LDX, OP_TAX, OP_TSX, OP_DEX, OP_INX: begin
        case (item.action)
          OP_LDX:  v = m;
          OP_TAX:  v = regs.acc;
          OP_TSX:  v = regs.sp;
          OP_DEX:  v = regs.xreg - 8'd1;
          default: v = regs.xreg + 8'd1;
        endcase
        ex.regs.xreg = v;
        fl[FL_Z] = (v == 8'd0);
        fl[FL_N] = v[7];
      end
      OP_STY, OP_STX, OP_STA: begin
        ex.wr      = 1'b1;
        ex.wr_addr = item.mem_address;
        ex.wr_data = (item.action == OP_STY) ? regs.yreg :
                     (item.action == OP_STX) ? regs.xreg : regs.acc;
      end
      OP_PHP, OP_PHA: begin
        ex.wr      = 1'b1;
        ex.wr_addr = {STACK_PAGE, regs.sp};
        ex.wr_data = (item.action == OP_PHP) ? regs.flags : regs.acc;
        ex.regs.sp = sp_m1;
      end
      OP_PLP: begin
        ex.regs.sp = regs.sp + 8'd1;
        fl = m;
      end
      OP_TXS: ex.regs.sp = regs.xreg;
      OP_CPY, OP_CMP, OP_CPX: begin
        fl[FL_C] = ~cmp[8];
        fl[FL_Z] = (cmp[7:0] == 8'd0);
        fl[FL_N] = cmp[7];
      end
      OP_BPL: begin is_br = 1'b1; cond = ~regs.flags[FL_N]; end
      OP_BMI: begin is_br = 1'b1; cond =  regs.flags[FL_N]; end
      OP_BVC: begin is_br = 1'b1; cond = ~regs.flags[FL_V]; end
      OP_BVS: begin is_br = 1'b1; cond =  regs.flags[FL_V]; end
      OP_BCC: begin is_br = 1'b1; cond = ~regs.flags[FL_C]; end
      OP_BCS: begin is_br = 1'b1; cond =  regs.flags[FL_C]; end
      OP_BNE: begin is_br = 1'b1; cond = ~regs.flags[FL_Z]; end
      OP_BEQ: begin is_br = 1'b1; cond =  regs.flags[FL_Z]; end
      default: ;
    endcase
    if (is_br && cond) ex.pc = item.pc_in + {{8{m[7]}}, m};
    ex.regs.flags = fl;
  end

endmodule
`default_nettype wire

[rtl/cpu8_execute_unit_top.sv]
// ----------------------------------------------------------------------------
// cpu8_execute_unit_top: 8-bit processor execute stage
// Keeps A, X, Y, SP and status; reports bus writes and state per item.
// ----------------------------------------------------------------------------
// Usage:
//   in_  channel carries one decoded instruction per item with its operands.
//   out_ channel carries result items: one per instruction, two for JSR and
//   three for BRK (the stack pushes), last set on the final one.
//   The instruction is executed in the cycle it is accepted; its first
//   result sits in the output register from the next cycle.
//   Throughput: one instruction per cycle while each gives one result and
//   out_ready is high; JSR and BRK hold the input until all their pushes are
//   sent by the result register, which sends one push per cycle while out_ready is high.
//   Reset clears A, X, Y, SP, status and the output valid flag, not the output data.
//   When out_ready is low the output register holds and in_ready falls as
//   soon as that register cannot be freed in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module cpu8_execute_unit_top import c8eu_pkg::*; (
  input  wire clk,
  input  wire rst_n,
  c8eu_in_if.sink    in_ch,
  c8eu_out_if.source out_ch
);

  regs_t     regs_r, regs_nxt;
  exec_t     ex;
  exec_t     hold_r, hold_nxt;     // multi-push instruction in progress
  logic [1:0] idx_r, idx_nxt;      // index of the next push to send
  logic      busy_r, busy_nxt;
  out_item_t out_r, out_nxt;
  logic      vld_r, vld_nxt;
  logic      slot_free;
  logic      acc_in;
  exec_t     cur;
  logic [1:0] cur_idx;
  logic      have;

  c8eu_alu u_alu (.item(in_ch.data), .regs(regs_r), .ex(ex));

  assign slot_free   = !vld_r || out_ch.ready;
  assign in_ch.ready = slot_free && !busy_r;
  assign acc_in      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = vld_r;
  assign out_ch.data  = out_r;

  always_comb begin
    regs_nxt = regs_r;
    hold_nxt = hold_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    vld_nxt  = vld_r && !out_ch.ready;
    out_nxt  = out_r;
    have     = 1'b0;
    cur      = hold_r;
    cur_idx  = idx_r;
    if (busy_r && slot_free) begin
      have = 1'b1;
    end else if (acc_in) begin
      have     = 1'b1;
      cur      = ex;
      cur_idx  = 2'd0;
      regs_nxt = ex.regs;
      hold_nxt = ex;
    end
    if (have) begin
      vld_nxt               = 1'b1;
      out_nxt.acc_out       = cur.regs.acc;
      out_nxt.xreg_out      = cur.regs.xreg;
      out_nxt.yreg_out      = cur.regs.yreg;
      out_nxt.sp_out        = cur.regs.sp;
      out_nxt.flags_out     = cur.regs.flags;
      out_nxt.pc_out        = cur.pc;
      out_nxt.last          = (cur_idx == cur.count);
      if (cur.pushes) begin
        out_nxt.bus_write   = 1'b1;
        out_nxt.bus_address = {STACK_PAGE, cur.sp_first - {6'd0, cur_idx}};
        out_nxt.bus_data    = (cur_idx == 2'd0) ? cur.push0 :
                              (cur_idx == 2'd1) ? cur.push1 : cur.push2;
      end else begin
        out_nxt.bus_write   = cur.wr;
        out_nxt.bus_address = cur.wr ? cur.wr_addr : 16'd0;
        out_nxt.bus_data    = cur.wr ? cur.wr_data : 8'd0;
      end
      busy_nxt = (cur_idx != cur.count);
      idx_nxt  = cur_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
      busy_r <= 1'b0;
      vld_r  <= 1'b0;
      idx_r  <= '0;
    end else begin
      regs_r <= regs_nxt;
      busy_r <= busy_nxt;
      vld_r  <= vld_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  // no new instruction while pushes are still pending
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !in_ch.ready)
    else $error("input taken during multi-push");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed under stall");

  // a push sequence never ends early
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && busy_r |-> !out_ch.data.last)
    else $error("last set with pushes pending");

  // registers move only when an instruction is taken
  a_regs: assert property (@(posedge clk) disable iff (!rst_n)
    !acc_in |=> $stable(regs_r))
    else $error("registers changed without an instruction");

endmodule
`default_nettype wire

[bench/tb_cpu8_execute_unit_top.sv]
// ----------------------------------------------------------------------------
// tb_cpu8_execute_unit_top: execute stage testbench
// Drives instructions through the input channel in bursts, stalls the result
// channel, and checks each result item against a behavioral predictor of the
// register file, stack pushes, flags and program counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_cpu8_execute_unit_top;
  import c8eu_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int N_RANDOM = 450;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  c8eu_in_if  in_ch ();
  c8eu_out_if out_ch ();

  cpu8_execute_unit_top DUT (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  // predictor state
  logic [7:0] p_acc, p_x, p_y, p_sp, p_fl;
  out_item_t  result_q[$];
  int         errors = 0;
  int         n_items = 0;
  int         n_results = 0;
  int         cycles = 0;

  function automatic out_item_t plain_result();
    out_item_t r;
    r = '0;
    return r;
  endfunction

  task automatic set_nz(input logic [7:0] v);
    p_fl[FL_Z] = (v == 8'h00);
    p_fl[FL_N] = v[7];
  endtask

  task automatic compare_reg(input logic [7:0] r, input logic [7:0] m);
    logic [7:0] d;
    d = r - m;
    p_fl[FL_C] = (r >= m);
    p_fl[FL_Z] = (r == m);
    p_fl[FL_N] = d[7];
  endtask

  task automatic add_carry(input logic [7:0] m);
    logic [8:0] s;
    s = {1'b0, p_acc} + {1'b0, m} + {8'd0, p_fl[FL_C]};
    p_fl[FL_V] = (~(p_acc[7] ^ m[7])) & (p_acc[7] ^ s[7]);
    p_fl[FL_C] = s[8];
    p_acc = s[7:0];
    set_nz(p_acc);
  endtask

  // compute the result items of one instruction and queue them
  task automatic predict_exec(input in_item_t it);
    out_item_t r[3];
    int n;
    logic [7:0] v;
    logic [15:0] pc_next;
    logic take;
    n = 1;
    take = 1'b0;
    pc_next = it.pc_in;
    for (int k = 0; k < 3; k++) r[k] = plain_result();
    case (it.action)
      OP_BRK: begin
        r[0].bus_write = 1'b1; r[0].bus_address = {STACK_PAGE, p_sp};
        r[0].bus_data = it.pc_in[15:8];
        p_sp = p_sp - 8'd1;
        r[1].bus_write = 1'b1; r[1].bus_address = {STACK_PAGE, p_sp};
        r[1].bus_data = it.pc_in[7:0];
        p_sp = p_sp - 8'd1;
        p_fl[FL_B] = 1'b1;
        r[2].bus_write = 1'b1; r[2].bus_address = {STACK_PAGE, p_sp}; r[2].bus_data = p_fl;
        p_sp = p_sp - 8'd1;
        pc_next = it.operand_word;
        n = 3;
      end
      OP_CLC: p_fl[FL_C] = 1'b0;
      OP_SEC: p_fl[FL_C] = 1'b1;
      OP_CLI: p_fl[FL_I] = 1'b0;
      OP_SEI: p_fl[FL_I] = 1'b1;
      OP_CLD: p_fl[FL_D] = 1'b0;
      OP_SED: p_fl[FL_D] = 1'b1;
      OP_CLV: p_fl[FL_V] = 1'b0;
      OP_ASL, OP_LSR, OP_ROL, OP_ROR, OP_DEC, OP_INC: begin
        case (it.action)
          OP_ASL: v = {it.operand[6:0], 1'b0};
          OP_LSR: v = {1'b0, it.operand[7:1]};
          OP_ROL: v = {it.operand[6:0], p_fl[FL_C]};
          OP_ROR: v = {p_fl[FL_C], it.operand[7:1]};
          OP_DEC: v = it.operand - 8'd1;
          default: v = it.operand + 8'd1;
        endcase
        if (it.action == OP_ASL || it.action == OP_ROL) p_fl[FL_C] = it.operand[7];
        if (it.action == OP_LSR || it.action == OP_ROR) p_fl[FL_C] = it.operand[0];
        set_nz(v);
        r[0].bus_write = 1'b1; r[0].bus_address = it.mem_address; r[0].bus_data = v;
      end
      OP_ADC: add_carry(it.operand);
      OP_SBC: add_carry(~it.operand);
      OP_BIT: begin
        p_fl[FL_Z] = ((p_acc & it.operand) == 8'h00);
        p_fl[FL_V] = it.operand[6];
        p_fl[FL_N] = it.operand[7];
      end
      OP_ORA: begin p_acc = p_acc | it.operand; set_nz(p_acc); end
      OP_AND: begin p_acc = p_acc & it.operand; set_nz(p_acc); end
      OP_EOR: begin p_acc = p_acc ^ it.operand; set_nz(p_acc); end
      OP_JSR: begin
        r[0].bus_write = 1'b1; r[0].bus_address = {STACK_PAGE, p_sp};
        r[0].bus_data = it.pc_in[15:8];
        p_sp = p_sp - 8'd1;
        r[1].bus_write = 1'b1; r[1].bus_address = {STACK_PAGE, p_sp};
        r[1].bus_data = it.pc_in[7:0];
        p_sp = p_sp - 8'd1;
        pc_next = it.operand_word;
        n = 2;
      end
      OP_JMP: pc_next = it.operand_word;
      OP_RTI: begin p_fl = it.operand; p_sp = p_sp + 8'd3; pc_next = it.operand_word; end
      OP_RTS: begin p_sp = p_sp + 8'd2; pc_next = it.operand_word; end
      OP_LDY: begin p_y = it.operand; set_nz(p_y); end
      OP_LDX: begin p_x = it.operand; set_nz(p_x); end
      OP_LDA: begin p_acc = it.operand; set_nz(p_acc); end
      OP_STY, OP_STX, OP_STA: begin
        r[0].bus_write = 1'b1; r[0].bus_address = it.mem_address;
        r[0].bus_data = (it.action == OP_STY) ? p_y : (it.action == OP_STX) ? p_x : p_acc;
      end
      OP_PHP, OP_PHA: begin
        r[0].bus_write = 1'b1; r[0].bus_address = {STACK_PAGE, p_sp};
        r[0].bus_data = (it.action == OP_PHP) ? p_fl : p_acc;
        p_sp = p_sp - 8'd1;
      end
      OP_PLA: begin p_sp = p_sp + 8'd1; p_acc = it.operand; set_nz(p_acc); end
      OP_PLP: begin p_sp = p_sp + 8'd1; p_fl = it.operand; end
      OP_TXA: begin p_acc = p_x; set_nz(p_acc); end
      OP_TYA: begin p_acc = p_y; set_nz(p_acc); end
      OP_TXS: p_sp = p_x;
      OP_TAY: begin p_y = p_acc; set_nz(p_y); end
      OP_TAX: begin p_x = p_acc; set_nz(p_x); end
      OP_TSX: begin p_x = p_sp; set_nz(p_x); end
      OP_CPY: compare_reg(p_y, it.operand);
      OP_CMP: compare_reg(p_acc, it.operand);
      OP_CPX: compare_reg(p_x, it.operand);
      OP_DEY: begin p_y = p_y - 8'd1; set_nz(p_y); end
      OP_DEX: begin p_x = p_x - 8'd1; set_nz(p_x); end
      OP_INY: begin p_y = p_y + 8'd1; set_nz(p_y); end
      OP_INX: begin p_x = p_x + 8'd1; set_nz(p_x); end
      OP_BPL: take = !p_fl[FL_N];
      OP_BMI: take = p_fl[FL_N];
      OP_BVC: take = !p_fl[FL_V];
      OP_BVS: take = p_fl[FL_V];
      OP_BCC: take = !p_fl[FL_C];
      OP_BCS: take = p_fl[FL_C];
      OP_BNE: take = !p_fl[FL_Z];
      OP_BEQ: take = p_fl[FL_Z];
      default: ;
    endcase
    if (take) pc_next = it.pc_in + {{8{it.operand[7]}}, it.operand};
    for (int k = 0; k < n; k++) begin
      r[k].acc_out = p_acc; r[k].xreg_out = p_x; r[k].yreg_out = p_y;
      r[k].sp_out = p_sp; r[k].flags_out = p_fl; r[k].pc_out = pc_next;
      r[k].last = (k == n - 1);
      result_q.push_back(r[k]);
    end
  endtask

  // result channel: stall pattern and checking
  logic [3:0] stall_lfsr = 4'b1011;
  int stall_mode = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        out_item_t want, got;
        got = out_ch.data;
        n_results++;
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result item %h", $time, got);
          errors++;
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, got);
            if (got.bus_write !== want.bus_write || got.bus_address !== want.bus_address ||
                got.bus_data !== want.bus_data)
              $display("%0t:   bus expected %b/%h/%h actual %b/%h/%h", $time,
                       want.bus_write, want.bus_address, want.bus_data,
                       got.bus_write, got.bus_address, got.bus_data);
            $display("%0t:   regs a x y sp p pc last expected %h %h %h %h %h %h %b actual %h %h %h %h %h %h %b",
                     $time, want.acc_out, want.xreg_out, want.yreg_out, want.sp_out,
                     want.flags_out, want.pc_out, want.last, got.acc_out, got.xreg_out,
                     got.yreg_out, got.sp_out, got.flags_out, got.pc_out, got.last);
            errors++;
          end
        end
      end
      // stretches of always-ready alternate with a pseudo-random stall pattern
      stall_lfsr <= {stall_lfsr[2:0], stall_lfsr[3] ^ stall_lfsr[2]};
      if (cycles % 97 == 0) stall_mode = $urandom_range(0, 2);
      out_ch.ready <= (stall_mode == 0) ? 1'b1 : (stall_mode == 1) ? stall_lfsr[0] :
                      (stall_lfsr[1:0] != 2'b00);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, result_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // directed table: expected results are filled in for the obvious rows only
  typedef struct {
    in_item_t   it;
    bit         known;
    logic [7:0] acc, fl, sp;
  } dir_row_t;

  dir_row_t rows[$];

  function automatic in_item_t mk(op_t a, logic [7:0] m, logic [15:0] w,
                                  logic [15:0] ad, logic [15:0] pc);
    in_item_t it;
    it.action = a; it.operand = m; it.operand_word = w; it.mem_address = ad; it.pc_in = pc;
    return it;
  endfunction

  function automatic dir_row_t row(in_item_t it, bit known = 1'b0, logic [7:0] a = 8'h00,
                                   logic [7:0] f = 8'h00, logic [7:0] s = 8'h00);
    dir_row_t r;
    r.it = it; r.known = known; r.acc = a; r.fl = f; r.sp = s;
    return r;
  endfunction

  task automatic send_item(input in_item_t it);
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_exec(it);
    n_items++;
  endtask

  task automatic idle_cycles(input int n);
    in_ch.valid <= 1'b0;
    in_ch.data  <= in_item_t'($urandom());
    repeat (n) @(posedge clk);
  endtask

  // random instruction; mostly meaningful ops, occasional unused codes
  function automatic in_item_t rand_item();
    in_item_t it;
    it.action = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(56, 63))
                                              : 6'($urandom_range(0, 55));
    it.operand = ($urandom_range(0, 4) == 0) ? (($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00)
                                             : 8'($urandom());
    it.operand_word = 16'($urandom());
    it.mem_address = 16'($urandom());
    it.pc_in = ($urandom_range(0, 9) == 0) ? 16'hFFF0 + 16'($urandom_range(0, 15))
                                           : 16'($urandom());
    return it;
  endfunction

  initial begin
    int burst;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    p_acc = 8'h00; p_x = 8'h00; p_y = 8'h00; p_sp = 8'h00; p_fl = 8'h00;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    rows.push_back(row(mk(OP_NOP, 8'h00, 16'h0000, 16'h0000, 16'h0000), 1'b1, 8'h00, 8'h00, 8'h00));
    rows.push_back(row(mk(OP_LDA, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1, 8'h00, 8'h02, 8'h00));
    rows.push_back(row(mk(OP_LDA, 8'h80, 16'h0000, 16'h0000, 16'h1234), 1'b1, 8'h80, 8'h80, 8'h00));
    rows.push_back(row(mk(OP_ADC, 8'h80, 16'h0000, 16'h0000, 16'h1234), 1'b1, 8'h00, 8'h43, 8'h00));
    rows.push_back(row(mk(OP_SBC, 8'h01, 16'h0000, 16'h0000, 16'h0000)));
    rows.push_back(row(mk(OP_ADC, 8'h7F, 16'h0000, 16'h0000, 16'h0000)));
    rows.push_back(row(mk(OP_BRK, 8'h00, 16'hFFFE, 16'h0000, 16'hABCD)));
    rows.push_back(row(mk(OP_JSR, 8'h00, 16'h8000, 16'h0000, 16'h00FF)));
    rows.push_back(row(mk(OP_RTS, 8'h00, 16'h00FF, 16'h0000, 16'h8003)));
    rows.push_back(row(mk(OP_RTI, 8'hFF, 16'hABCD, 16'h0000, 16'h0000)));
    rows.push_back(row(mk(OP_BMI, 8'h80, 16'h0000, 16'h0000, 16'h0010)));
    rows.push_back(row(mk(OP_BPL, 8'h7F, 16'h0000, 16'h0000, 16'hFFF0)));
    rows.push_back(row(mk(OP_PLP, 8'h00, 16'h0000, 16'h0000, 16'h0000)));
    rows.push_back(row(mk(OP_BNE, 8'h7F, 16'h0000, 16'h0000, 16'hFFF0)));
    rows.push_back(row(mk(OP_ROR, 8'h01, 16'h0000, 16'hFFFF, 16'h0000)));
    rows.push_back(row(mk(OP_ROL, 8'h80, 16'h0000, 16'h0100, 16'h0000)));
    rows.push_back(row(mk(OP_LDX, 8'hFF, 16'h0000, 16'h0000, 16'h0000)));
    rows.push_back(row(mk(OP_TXS, 8'h00, 16'h0000, 16'h0000, 16'h0000)));
    rows.push_back(row(mk(OP_PHA, 8'h00, 16'h0000, 16'h0000, 16'h0000)));
    rows.push_back(row(mk(OP_INX, 8'h00, 16'h0000, 16'h0000, 16'h0000)));
    rows.push_back(row(mk(OP_STX, 8'h00, 16'h0000, 16'hFFFF, 16'h0000)));
    rows.push_back(row(mk(OP_CPX, 8'h01, 16'h0000, 16'h0000, 16'h0000)));
    rows.push_back(row(mk(OP_BIT, 8'hC0, 16'h0000, 16'h0000, 16'h0000)));
    rows.push_back(row(mk(op_t'(6'd63), 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF)));

    @(posedge clk);
    foreach (rows[i]) begin
      send_item(rows[i].it);
      // typed-in expectations cross-check the predictor itself; the newest
      // queued item belongs to this row
      if (rows[i].known && (result_q[$].acc_out !== rows[i].acc ||
          result_q[$].flags_out !== rows[i].fl ||
          result_q[$].sp_out !== rows[i].sp)) begin
        $display("%0t: row %0d expected a/p/sp %h/%h/%h actual %h/%h/%h", $time, i,
                 rows[i].acc, rows[i].fl, rows[i].sp, result_q[$].acc_out,
                 result_q[$].flags_out, result_q[$].sp_out);
        errors++;
      end
    end

    // drain fully once before random traffic
    in_ch.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);

    for (int i = 0; i < N_RANDOM; ) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst && i < N_RANDOM; b++, i++) send_item(rand_item());
      if (i == N_RANDOM / 2) begin
        in_ch.valid <= 1'b0;
        while (result_q.size() != 0) @(posedge clk);
      end else if ($urandom_range(0, 2) != 0) begin
        idle_cycles($urandom_range(1, 6));
      end
    end
    in_ch.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("ran %0d instructions giving %0d result items, with bursts, gaps and stalls",
             n_items, n_results);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d errors", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

[sim.f]
rtl/c8eu_pkg.sv
rtl/c8eu_if.sv
rtl/c8eu_alu.sv
rtl/cpu8_execute_unit_top.sv
bench/tb_cpu8_execute_unit_top.sv
